### sv/fbpa_pkg.sv
// Shared constants, types and helpers for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;

  localparam int ADDR_W  = 48;
  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 9;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(4);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(24);

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 3;

  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT     = REG_IDX_W'(2);

  localparam logic [ADDR_W-1:0]  RST_POOL_BASE       = '0;
  localparam logic [SHIFT_W-1:0] RST_BLOCK_SIZE_LOG2 = SHIFT_W'(12);
  localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT     = COUNT_W'(256);

  localparam logic OP_LEASE   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EXHAUSTED   = 2'd1,
    STATUS_BAD_RELEASE = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pool_base;
    logic [SHIFT_W-1:0] block_size_log2;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

  // Block size log2 clamped to the supported range.
  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] sh);
    logic [SHIFT_W-1:0] res;
    res = sh;
    if (sh < SHIFT_MIN) res = SHIFT_MIN;
    if (sh > SHIFT_MAX) res = SHIFT_MAX;
    return res;
  endfunction

  // Block count clamped to the pool capacity.
  function automatic logic [LINK_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
    logic [LINK_W-1:0] res;
    if (32'(cnt) > MAX_BLOCKS) res = LINK_W'(MAX_BLOCKS);
    else                       res = LINK_W'(cnt);
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/fbpa_cfg.sv
// APB configuration registers of the block pool allocator.
`default_nettype none

module fbpa_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbpa_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fbpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [fbpa_pkg::APB_DATA_W-1:0] prdata,
  output fbpa_pkg::cfg_t                       cfg
);
  import fbpa_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_base       <= RST_POOL_BASE;
      cfg_r.block_size_log2 <= RST_BLOCK_SIZE_LOG2;
      cfg_r.block_count     <= RST_BLOCK_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POOL_BASE:       cfg_r.pool_base       <= pwdata[ADDR_W-1:0];
        REG_BLOCK_SIZE_LOG2: cfg_r.block_size_log2 <= pwdata[SHIFT_W-1:0];
        REG_BLOCK_COUNT:     cfg_r.block_count     <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POOL_BASE:       prdata = APB_DATA_W'(cfg_r.pool_base);
      REG_BLOCK_SIZE_LOG2: prdata = APB_DATA_W'(cfg_r.block_size_log2);
      REG_BLOCK_COUNT:     prdata = APB_DATA_W'(cfg_r.block_count);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### sv/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request register, free list and result register.
//
//   Channel | Direction | Handshake              | Payload
//   in_     | request   | in_valid / in_stall    | in_operation, in_release_address
//   out_    | result    | out_valid / out_stall  | out_block_address, out_status
//   APB     | config    | psel, penable, pready  | paddr, pwdata, prdata
//
// A request is captured in the input register and resolved from it once the result register
// can take a result, so the block takes no new request before the held one is resolved.
// The link memory requires this: its registered read of the entry at the free-list head
// must follow each head update. The input stalls whenever a request is held; a stalled
// result register keeps that request, and so the input stall, in place until the result is taken.
// Reset empties the free list and the fresh count; the link memory is not cleared.
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]     in_release_address,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fbpa_pkg::ADDR_W-1:0]     out_block_address,
  output logic      [1:0]                      out_status,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbpa_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fbpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [fbpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import fbpa_pkg::*;

  cfg_t cfg;

  // Request register
  logic              busy_r, busy_nxt;
  logic              op_r;
  logic [ADDR_W-1:0] off_r;

  // Free list state
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] fresh_r, fresh_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  status_t           out_status_r, out_status_nxt;

  // Link memory
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_rdata;

  logic              in_take;
  logic              resolve;
  logic [SHIFT_W-1:0] sh;
  logic [LINK_W-1:0] cnt;
  logic [ADDR_W-1:0] low_mask;
  logic [ADDR_W-1:0] rel_idx;
  logic [LINK_W-1:0] lease_idx;
  logic [ADDR_W-1:0] lease_addr;

  fbpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // The read port always follows the head, so the next entry is ready in the cycle
  // after the head moves.
  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (head_r),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  assign in_stall = busy_r;
  assign in_take  = in_valid & ~busy_r;
  assign resolve  = busy_r & (~out_valid_r | ~out_stall);

  assign sh       = eff_shift(cfg.block_size_log2);
  assign cnt      = eff_count(cfg.block_count);
  assign low_mask = ~({ADDR_W{1'b1}} << sh);
  assign rel_idx  = off_r >> sh;

  assign lease_idx  = (head_r < LINK_W'(MAX_BLOCKS)) ? head_r : fresh_r;
  assign lease_addr = cfg.pool_base + (ADDR_W'(lease_idx) << sh);

  assign link_waddr = rel_idx[IDX_W-1:0];

  always_comb begin
    busy_nxt       = busy_r;
    head_nxt       = head_r;
    fresh_nxt      = fresh_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    link_we        = 1'b0;

    if (in_take) begin
      busy_nxt = 1'b1;
    end

    if (resolve) begin
      busy_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = '0;
      out_status_nxt = STATUS_OK;
      if (op_r == OP_LEASE) begin
        if (head_r < LINK_W'(MAX_BLOCKS)) begin
          out_addr_nxt = lease_addr;
          head_nxt     = link_rdata;
        end else if (fresh_r < cnt) begin
          out_addr_nxt = lease_addr;
          fresh_nxt    = fresh_r + LINK_W'(1);
        end else begin
          out_status_nxt = STATUS_EXHAUSTED;
        end
      end else begin
        if (((off_r & low_mask) != '0) || (rel_idx >= ADDR_W'(cnt))) begin
          out_status_nxt = STATUS_BAD_RELEASE;
        end else begin
          link_we  = 1'b1;
          head_nxt = LINK_W'(rel_idx[IDX_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      head_r      <= LINK_W'(MAX_BLOCKS);
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The pool offset is taken at capture time; the user must keep configuration quiet while busy (not enforced here).
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_operation;
      off_r <= in_release_address - cfg.pool_base;
    end
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

### bench/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator against a free-list predictor.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int WATCHDOG_LIMIT       = 4000;
  localparam int MAX_MISMATCH_REPORTS = 10;
  localparam int PHASE_ITEMS          = 137;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
  } alloc_result_t;

  // Tracks the pool state and the results still owed by the block.
  class pool_scoreboard;
    logic [ADDR_W-1:0]  pool_base;
    logic [SHIFT_W-1:0] size_log2;
    logic [COUNT_W-1:0] block_count;
    logic [LINK_W-1:0]  free_top;
    logic [LINK_W-1:0]  next_free [MAX_BLOCKS];
    logic [LINK_W-1:0]  fresh_used;
    alloc_result_t      owed_results [$];
    int                 mismatches;

    function new();
      pool_base   = RST_POOL_BASE;
      size_log2   = RST_BLOCK_SIZE_LOG2;
      block_count = RST_BLOCK_COUNT;
      free_top    = LINK_W'(MAX_BLOCKS);
      fresh_used  = '0;
      mismatches  = 0;
      foreach (next_free[i]) next_free[i] = '0;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_POOL_BASE:       pool_base   = value[ADDR_W-1:0];
        REG_BLOCK_SIZE_LOG2: size_log2   = value[SHIFT_W-1:0];
        REG_BLOCK_COUNT:     block_count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned shift_used();
      if (size_log2 < SHIFT_MIN) return SHIFT_MIN;
      if (size_log2 > SHIFT_MAX) return SHIFT_MAX;
      return size_log2;
    endfunction

    function int unsigned count_used();
      return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
    endfunction

    function logic [ADDR_W-1:0] block_addr(int unsigned idx);
      return pool_base + (ADDR_W'(idx) << shift_used());
    endfunction

    function alloc_result_t note_request(logic op, logic [ADDR_W-1:0] addr);
      alloc_result_t     res;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] idx;
      logic [ADDR_W-1:0] low_mask;
      res.block_address = '0;
      res.status        = STATUS_OK;
      if (op == OP_LEASE) begin
        if (free_top < MAX_BLOCKS) begin
          res.block_address = block_addr(free_top);
          free_top = next_free[free_top[IDX_W-1:0]];
        end else if (fresh_used < count_used()) begin
          res.block_address = block_addr(fresh_used);
          fresh_used = fresh_used + LINK_W'(1);
        end else begin
          res.status = STATUS_EXHAUSTED;
        end
      end else begin
        offset   = addr - pool_base;
        low_mask = (ADDR_W'(1) << shift_used()) - ADDR_W'(1);
        idx      = offset >> shift_used();
        if ((offset & low_mask) != '0 || idx >= count_used()) begin
          res.status = STATUS_BAD_RELEASE;
        end else begin
          next_free[idx[IDX_W-1:0]] = free_top;
          free_top = LINK_W'(idx);
        end
      end
      owed_results.push_back(res);
      return res;
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] status);
      alloc_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_REPORTS)
          $display("unexpected result: address %h status %0d", addr, status);
        return;
      end
      want = owed_results.pop_front();
      if (addr !== want.block_address || status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_REPORTS)
          $display("result mismatch: expected address %h status %0d, got address %h status %0d",
                   want.block_address, want.status, addr, status);
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_operation;
  logic [ADDR_W-1:0]     in_release_address;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_block_address;
  logic [1:0]            out_status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pool_scoreboard    board = new();
  logic [ADDR_W-1:0] held_blocks [$];
  logic [ADDR_W-1:0] last_released = '0;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                stall_left = 0;
  int                idle_cycles = 0;

  fixed_block_pool_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_block_address  (out_block_address),
    .out_status         (out_status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_result(out_block_address, out_status);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_register(idx, value);
    @(posedge clk);
  endtask

  // Registers change only once every owed result has come back.
  task automatic configure(input logic [ADDR_W-1:0] base, input int unsigned shift,
                           input int unsigned count);
    in_valid <= 1'b0;
    while (board.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(REG_POOL_BASE, APB_DATA_W'(base));
    apb_write(REG_BLOCK_SIZE_LOG2, APB_DATA_W'(shift));
    apb_write(REG_BLOCK_COUNT, APB_DATA_W'(count));
    held_blocks.delete();
  endtask

  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
    alloc_result_t res;
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_release_address <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = board.note_request(op, addr);
    if (op == OP_LEASE && res.status == STATUS_OK) held_blocks.push_back(res.block_address);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Mostly leases and releases of blocks that are out, with some
  // misaligned, out-of-range, repeated and arbitrary release addresses.
  task automatic pick_request(output logic op, output logic [ADDR_W-1:0] addr);
    int unsigned r;
    int unsigned shift;
    int unsigned count;
    int unsigned k;
    shift = board.shift_used();
    count = board.count_used();
    r     = $urandom_range(0, 99);
    op    = OP_RELEASE;
    addr  = ADDR_W'({$urandom(), $urandom()});
    if (r < 45) begin
      op = OP_LEASE;
    end else if (r < 75) begin
      if (held_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
        k    = $urandom_range(0, held_blocks.size() - 1);
        addr = held_blocks[k];
        held_blocks.delete(k);
      end else if (count != 0) begin
        addr = board.block_addr($urandom_range(0, count - 1));
      end
      last_released = addr;
    end else if (r < 80) begin
      addr = last_released;
    end else if (r < 88) begin
      addr = board.block_addr($urandom_range(0, count)) +
             ADDR_W'($urandom_range(1, (1 << shift) - 1));
    end else if (r < 94) begin
      addr = board.block_addr(count + $urandom_range(0, 300));
    end
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input int unsigned shift,
                           input int unsigned count, input int stall, input int gap);
    logic              op;
    logic [ADDR_W-1:0] addr;
    configure(base, shift, count);
    stall_pct = stall;
    gap_pct   = gap;
    repeat (PHASE_ITEMS) begin
      pick_request(op, addr);
      send_request(op, addr);
    end
  endtask

  function automatic logic [ADDR_W-1:0] any_base();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    in_valid           <= 1'b0;
    in_operation       <= OP_LEASE;
    in_release_address <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    rst_n              <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: fresh blocks, reuse from the free list, bad releases
    // and a block released twice.
    stall_pct = 20;
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '1);
    send_request(OP_RELEASE, 48'h1000);
    send_request(OP_LEASE, '0);
    send_request(OP_RELEASE, 48'h0);
    send_request(OP_RELEASE, 48'h1000);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);
    send_request(OP_RELEASE, 48'h1001);
    send_request(OP_RELEASE, 48'h10_0000);
    send_request(OP_RELEASE, 48'hFFFF_FFFF_FFFF);
    send_request(OP_RELEASE, 48'h2000);
    send_request(OP_RELEASE, 48'h2000);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);

    // Pool wrapping past the top of the address space, undersized block
    // shift, and a count lowered below the blocks already handed out.
    configure(48'hFFFF_FFFF_FFF0, 3, 2);
    send_request(OP_LEASE, '0);
    send_request(OP_RELEASE, 48'hFFFF_FFFF_FFF0);
    send_request(OP_RELEASE, 48'h0);
    send_request(OP_RELEASE, 48'h10);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);
    send_request(OP_LEASE, '0);

    run_phase('0, 12, 256, 10, 10);
    run_phase('1, 4, 1, 30, 0);
    run_phase(any_base(), 24, 256, 0, 30);
    run_phase(any_base(), 0, 300, 15, 15);
    run_phase(any_base(), 31, 0, 20, 20);
    run_phase(any_base(), $urandom_range(4, 24), $urandom_range(1, 16), 30, 30);
    run_phase(any_base(), $urandom_range(4, 24), 511, 10, 10);
    run_phase(any_base(), $urandom_range(0, 31), $urandom_range(0, 511), 20, 5);
    run_phase(any_base(), $urandom_range(0, 31), $urandom_range(1, 64), 0, 0);

    in_valid <= 1'b0;
    while (board.owed() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### fixed_block_pool_allocator.f
sv/fbpa_pkg.sv
sv/fbpa_ram.sv
sv/fbpa_cfg.sv
sv/fixed_block_pool_allocator.sv
bench/tb_fixed_block_pool_allocator.sv
